// ===== rtl/core/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared command, result and state types and the fixed codes of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic REG_FG = 1'b0;
  localparam logic REG_BG = 1'b1;

  localparam logic [3:0] FG_RESET = 4'hF;
  localparam logic [3:0] BG_RESET = 4'h0;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] BLANK_ATTR   = 8'h0F;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_SET,
    OP_CLEAR,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } res_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SHIFT,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/core/tcw_fifo.sv =====
// ----------------------------------------------------------------------------
// Small request queue
// Register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/tcw_front.sv =====
// ----------------------------------------------------------------------------
// Console command front end
// Accepts requests, classifies them and clamps coordinates into the queue.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    command,
  input  logic [7:0]    char_code,
  input  logic [4:0]    row,
  input  logic [6:0]    col,
  input  logic          busy,
  output logic          cmd_valid,
  output tcw_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  import tcw_pkg::*;

  cmd_t                cmd_in;
  logic                q_full;
  logic                q_empty;
  logic [$bits(cmd_t)-1:0] q_dout;

  always_comb begin
    cmd_in.ch  = char_code;
    cmd_in.row = (int'(row) > ROWS - 1) ? 5'(ROWS - 1) : row;
    cmd_in.col = (int'(col) > COLS - 1) ? 7'(COLS - 1) : col;
    unique case (command)
      CMD_PUT:   cmd_in.op = (char_code == NEWLINE_CODE) ? OP_NEWLINE : OP_PUT;
      CMD_SET:   cmd_in.op = OP_SET;
      CMD_CLEAR: cmd_in.op = OP_CLEAR;
      CMD_READ:  cmd_in.op = OP_READ;
    endcase
  end

  assign full      = q_full || busy;
  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_dout);

  tcw_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push && !full),
    .din  (cmd_in),
    .full (q_full),
    .pop  (cmd_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

endmodule

// ===== rtl/core/tcw_back.sv =====
// ----------------------------------------------------------------------------
// Console command back end
// Owns the cell memory and cursor and carries out queued requests.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    attr,
  input  logic          cmd_valid,
  input  tcw_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          busy,
  input  logic          res_full,
  output logic          res_push,
  output tcw_pkg::res_t res
);

  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  localparam logic [AW-1:0] COLS_A     = AW'(COLS);
  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] SHIFT_LAST = AW'(CELLS - COLS);
  localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST   = CW'(COLS - 1);

  state_t state;
  state_t state_next;

  logic [15:0]   mem [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;

  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] cur_base;
  logic [AW-1:0] cnt;
  logic [AW-1:0] rd_addr;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          pend_zero;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;
  logic          res_scrolled;
  logic          scroll_now;
  logic          cnt_last;

  assign scroll_now = (cmd.op == OP_NEWLINE || (cmd.op == OP_PUT && cur_col == COL_LAST))
                      && cur_row == ROW_LAST;
  assign cnt_last   = (cnt == LAST_CELL);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (cnt_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_PUT, OP_NEWLINE: state_next = scroll_now ? ST_SHIFT : ST_RESULT;
            OP_SET:             state_next = ST_RESULT;
            OP_CLEAR:           state_next = ST_CLEAR;
            OP_READ:            state_next = ST_READ;
            default:            state_next = ST_RESULT;
          endcase
        end
      end
      ST_SHIFT, ST_CLEAR: begin
        if (cnt_last) state_next = ST_RESULT;
      end
      ST_READ:      state_next = ST_READ_WAIT;
      ST_READ_WAIT: state_next = ST_RESULT;
      ST_RESULT: begin
        if (!res_full) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_pop   = (state == ST_IDLE) && cmd_valid;
    res_push  = (state == ST_RESULT) && !res_full;
    busy      = (state == ST_INIT);
    mem_raddr = (state == ST_SHIFT) ? ((cnt < SHIFT_LAST) ? cnt + COLS_A : '0) : rd_addr;
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = {BLANK_ATTR, SPACE_CODE};
    if (pend) begin
      mem_we    = 1'b1;
      mem_waddr = pend_addr;
      mem_wdata = pend_zero ? 16'h0000 : mem_rdata;
    end else if (state == ST_IDLE && cmd_valid && cmd.op == OP_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = cur_base + AW'(cur_col);
      mem_wdata = {attr, cmd.ch};
    end else if (state == ST_INIT || state == ST_CLEAR) begin
      mem_we = 1'b1;
    end
    res.cursor_row = 5'(cur_row);
    res.cursor_col = 7'(cur_col);
    res.cell_char  = res_char;
    res.cell_attr  = res_attr;
    res.scrolled   = res_scrolled;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      cur_row  <= '0;
      cur_col  <= '0;
      cur_base <= '0;
      pend     <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= (state == ST_SHIFT);
      pend_addr <= cnt;
      pend_zero <= (cnt >= SHIFT_LAST);
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cnt          <= '0;
            res_char     <= '0;
            res_attr     <= '0;
            res_scrolled <= 1'b0;
            unique case (cmd.op)
              OP_PUT: begin
                res_scrolled <= scroll_now;
                if (cur_col == COL_LAST) begin
                  cur_col <= '0;
                  if (cur_row != ROW_LAST) begin
                    cur_row  <= cur_row + 1'b1;
                    cur_base <= cur_base + COLS_A;
                  end
                end else begin
                  cur_col <= cur_col + 1'b1;
                end
              end
              OP_NEWLINE: begin
                res_scrolled <= scroll_now;
                cur_col      <= '0;
                if (cur_row != ROW_LAST) begin
                  cur_row  <= cur_row + 1'b1;
                  cur_base <= cur_base + COLS_A;
                end
              end
              OP_SET: begin
                cur_row  <= RW'(cmd.row);
                cur_col  <= CW'(cmd.col);
                cur_base <= AW'(cmd.row) * COLS_A;
              end
              OP_CLEAR: begin
                cur_row  <= '0;
                cur_col  <= '0;
                cur_base <= '0;
              end
              OP_READ: begin
                rd_addr <= AW'(cmd.row) * COLS_A + AW'(cmd.col);
              end
              default: begin
                res_scrolled <= 1'b0;
              end
            endcase
          end
        end
        ST_INIT, ST_SHIFT, ST_CLEAR: begin
          if (!cnt_last) cnt <= cnt + 1'b1;
        end
        ST_READ_WAIT: begin
          res_char <= mem_rdata[7:0];
          res_attr <= mem_rdata[15:8];
        end
        ST_READ, ST_RESULT: begin
          cnt <= '0;
        end
        default: begin
          cnt <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Text-mode screen store with cursor, scrolling, clearing and cell readback.
// ----------------------------------------------------------------------------
// Requests enter through push/full and carry command, char_code, row and col.
// Each request gives exactly one result, taken through empty/pop, oldest first.
// Colors are set through the register port: foreground at 0x0, background at
// 0x4; they must only be changed while no request is in flight.
// A put into the last cell or a newline on the last row shifts the whole
// screen up one row through the cell memory; a clear screen sweeps every
// cell in the same way.
// After reset the cell memory is filled with white-on-black spaces, during
// which full stays high.
// Two-entry queues sit on both sides: new requests are taken while results
// wait, and when the receiver stops popping the unit stalls once the result
// queue fills, then full rises once the request queue fills as well.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [7:0]  char_code,
  input  logic [4:0]  row,
  input  logic [6:0]  col,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_attr,
  output logic        scrolled,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tcw_pkg::*;

  logic [3:0]              fg;
  logic [3:0]              bg;
  logic                    busy;
  logic                    cmd_valid;
  cmd_t                    cmd;
  logic                    cmd_pop;
  logic                    res_full;
  logic                    res_push;
  res_t                    res_in;
  res_t                    res_out;
  logic [$bits(res_t)-1:0] res_dout;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg <= FG_RESET;
      bg <= BG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_FG: fg <= pwdata[3:0];
        REG_BG: bg <= pwdata[3:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FG: prdata = {28'b0, fg};
      REG_BG: prdata = {28'b0, bg};
    endcase
  end

  tcw_front #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .command  (command),
    .char_code(char_code),
    .row      (row),
    .col      (col),
    .busy     (busy),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  tcw_back #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .attr     ({bg, fg}),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .busy     (busy),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  tcw_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(2)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (res_in),
    .full (res_full),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign res_out    = res_t'(res_dout);
  assign cursor_row = res_out.cursor_row;
  assign cursor_col = res_out.cursor_col;
  assign cell_char  = res_out.cell_char;
  assign cell_attr  = res_out.cell_attr;
  assign scrolled   = res_out.scrolled;

endmodule
